[hdl/cwc_pkg.sv]
// ----------------------------------------------------------------------------
// cwc_pkg: shared types and constants of the congestion window controller
// Input and result word layouts, register indexes and default settings.
// ----------------------------------------------------------------------------
`default_nettype none

package cwc_pkg;

    localparam int FRAC_BITS_DFLT = 16;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_THR    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_LIMIT = 1'b1;

    // Event kinds
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_ACK  = 1'b1;

    localparam logic [15:0] INIT_THR_RST    = 16'd10000;
    localparam logic [31:0] DELAY_LIMIT_RST = 32'd100;

    typedef struct packed {
        logic        command;
        logic        sent_after_timeout;
        logic [31:0] send_time_ms;
        logic [31:0] ack_time_ms;
    } t_in_word;

    typedef struct packed {
        logic [15:0] window_whole;
        logic [15:0] window_fraction;
        logic        collapsed;
    } t_out_word;

endpackage : cwc_pkg

`default_nettype wire

[hdl/congestion_window_controller.sv]
// ----------------------------------------------------------------------------
// congestion_window_controller: slow start and congestion avoidance window
// Keeps a fixed-point congestion window and slow-start threshold, updated per
// send or ack event, with a restoring divider for the 1/window step.
// ----------------------------------------------------------------------------
// An event word is taken when o_in_ready is high and produces exactly one
// result word. A send event goes from S_EVAL to S_DONE; an ack below the
// threshold goes through S_EVAL and S_GROW, where the single saturating
// adder adds 1.0. An ack at or above the threshold runs the reciprocal
// through a one-bit-per-cycle restoring divider, 2*FRAC_BITS+1 steps, and
// the same adder adds it in S_ADD. The next word is accepted while a
// finished result still waits in the output register. A write to
// initial_threshold also reloads the threshold at once.
`default_nettype none

module congestion_window_controller #(
    parameter int FRAC_BITS = cwc_pkg::FRAC_BITS_DFLT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire cwc_pkg::t_in_word                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output cwc_pkg::t_out_word                    o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [cwc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [cwc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cwc_pkg::*;

    localparam int          QW     = 2 * FRAC_BITS + 1;
    localparam int          QEW    = (QW > 32) ? QW : 33;
    localparam int          TW     = 16 + FRAC_BITS;
    localparam int          TEW    = (TW > 32) ? TW : 33;
    localparam int          CW     = $clog2(QW);
    localparam logic [CW-1:0] CNT_TOP = CW'(QW - 1);
    localparam int          FR_SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int          FR_SH_L = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam logic [31:0] ONE_Q   = 32'(1) << FRAC_BITS;
    localparam logic [31:0] FR_MASK = ONE_Q - 32'd1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_GROW = 6'b000100,
        S_DIV  = 6'b001000,
        S_ADD  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state          r_state;
    t_in_word        r_item;
    t_out_word       r_out;
    logic            r_out_valid;
    logic [31:0]     r_limit;
    logic [31:0]     r_window;
    logic [31:0]     r_thr;
    logic            r_coll;
    logic [31:0]     r_rem;
    logic [QW-1:0]   r_quo;
    logic [CW-1:0]   r_cnt;

    // Datagram count to fixed point, saturating when it does not fit
    function automatic logic [31:0] thr_conv(input logic [15:0] d);
        logic [TEW-1:0] v;
        v = TEW'(d) << FRAC_BITS;
        return (|v[TEW-1:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    logic           in_acc;
    logic           cfg_thr_we;
    logic [31:0]    delay;
    logic           delay_over;
    logic           do_coll;
    logic [32:0]    rem_sh;
    logic           rem_ge;
    logic [QEW-1:0] quo_ext;
    logic [31:0]    recip;
    logic [31:0]    add_b;
    logic [32:0]    add_sum;
    logic [31:0]    add_sat;
    logic [31:0]    frac_full;
    logic           out_free;

    assign in_acc     = i_in_valid && o_in_ready;
    assign cfg_thr_we = i_cfg_we && (i_cfg_index == CFG_INIT_THR);

    assign delay      = r_item.ack_time_ms - r_item.send_time_ms;
    assign delay_over = delay > r_limit;
    assign do_coll    = (r_item.command == CMD_ACK) ? delay_over
                                                    : r_item.sent_after_timeout;

    // Dividend is 2^(2*FRAC_BITS): a single one in the first step
    assign rem_sh = {r_rem, (r_cnt == CNT_TOP)};
    assign rem_ge = rem_sh >= {1'b0, r_window};

    assign quo_ext = QEW'(r_quo);
    always_comb begin
        if (r_window == 32'd0) begin
            recip = 32'hFFFF_FFFF;
        end else if (|quo_ext[QEW-1:32]) begin
            recip = 32'hFFFF_FFFF;
        end else begin
            recip = quo_ext[31:0];
        end
    end

    // Shared saturating adder: +1.0 in slow start, +1/window otherwise
    assign add_b   = (r_state == S_ADD) ? recip : ONE_Q;
    assign add_sum = {1'b0, r_window} + {1'b0, add_b};
    assign add_sat = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];

    assign frac_full = r_window & FR_MASK;
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_limit     <= DELAY_LIMIT_RST;
            r_window    <= ONE_Q;
            r_thr       <= thr_conv(INIT_THR_RST);
            r_coll      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DELAY_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_coll <= do_coll;
                    if (do_coll) begin
                        r_window <= ONE_Q;
                        if (!cfg_thr_we) begin
                            r_thr <= r_window >> 1;
                        end
                    end
                    r_state <= (r_item.command == CMD_ACK) ? S_GROW : S_DONE;
                end
                S_GROW: begin
                    if (r_window < r_thr) begin
                        r_window <= add_sat;
                        r_state  <= S_DONE;
                    end else begin
                        r_cnt   <= CNT_TOP;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_window <= add_sat;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (cfg_thr_we) begin
                r_thr <= thr_conv(i_cfg_data[15:0]);
            end
        end
    end

    // Payload: item capture, divider datapath, result word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == S_GROW) begin
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_state == S_DIV) begin
            r_rem <= rem_ge ? 32'(rem_sh - {1'b0, r_window}) : rem_sh[31:0];
            r_quo <= {r_quo[QW-2:0], rem_ge};
        end
        if (r_state == S_DONE && out_free) begin
            r_out.window_whole    <= 16'(r_window >> FRAC_BITS);
            r_out.window_fraction <= 16'((frac_full >> FR_SH_R) << FR_SH_L);
            r_out.collapsed       <= r_coll;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_EVAL)
        else $error("accepted word did not start evaluation");

    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window != 32'd0)
        else $error("window reached zero");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> r_state == S_ADD)
        else $error("divider did not hand over to the add step");

    a_thr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_thr_we |=> r_thr == thr_conv($past(i_cfg_data[15:0])))
        else $error("threshold write not loaded");

endmodule : congestion_window_controller

`default_nettype wire

[bench/tb_congestion_window_controller.sv]
// ----------------------------------------------------------------------------
// tb_congestion_window_controller: self-checking bench for the window controller
// Walks a directed table of events and register writes, then runs randomized
// phases under several settings. Each result word is compared with its table
// word or a bit-accurate window predictor; both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_congestion_window_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import cwc_pkg::*;

    localparam int          FRAC        = FRAC_BITS_DFLT;
    localparam logic [31:0] ONE_Q       = 32'd1 << FRAC;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 192;
    localparam int          MAX_PRINTS  = 40;

    typedef enum bit {ROW_EVENT, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic [CFG_INDEX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        t_in_word                ev;
        bit                      typed;
        t_out_word               want;
    } t_plan_row;

    logic                    i_clk     = 1'b0;
    logic                    i_rst_n   = 1'b0;
    logic                    in_valid  = 1'b0;
    t_in_word                in_data   = '0;
    logic                    out_ready = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    in_ready;
    logic                    out_valid;
    t_out_word               out_data;

    // predictor state and settings
    logic [31:0] cwnd_q;
    logic [31:0] ssthresh_q;
    logic [15:0] thr_setting;
    logic [31:0] delay_limit;

    t_out_word   pending_windows[$];
    t_plan_row   plan[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          send_burst     = 1'b0;
    bit          recv_burst     = 1'b0;

    congestion_window_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] thr_to_fixed(input logic [15:0] datagrams);
        logic [47:0] wide;
        wide = {32'd0, datagrams} << FRAC;
        return (wide > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    function automatic void collapse_window();
        ssthresh_q = cwnd_q >> 1;
        cwnd_q     = ONE_Q;
    endfunction

    function automatic t_out_word advance_window(input t_in_word w);
        t_out_word   r;
        logic [31:0] lag;
        logic [31:0] frac;
        logic [63:0] recip;
        logic [32:0] sum;
        r.collapsed = 1'b0;
        if (w.command == CMD_SEND) begin
            if (w.sent_after_timeout) begin
                collapse_window();
                r.collapsed = 1'b1;
            end
        end else begin
            lag = w.ack_time_ms - w.send_time_ms;
            if (lag > delay_limit) begin
                collapse_window();
                r.collapsed = 1'b1;
            end
            if (cwnd_q < ssthresh_q) begin
                sum = {1'b0, cwnd_q} + {1'b0, ONE_Q};
            end else begin
                if (cwnd_q == 32'd0)
                    recip = 64'hFFFF_FFFF;
                else
                    recip = (64'd1 << (2 * FRAC)) / {32'd0, cwnd_q};
                if (recip > 64'hFFFF_FFFF)
                    recip = 64'hFFFF_FFFF;
                sum = {1'b0, cwnd_q} + {1'b0, recip[31:0]};
            end
            cwnd_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        frac = cwnd_q & (ONE_Q - 32'd1);
        r.window_whole    = 16'(cwnd_q >> FRAC);
        r.window_fraction = (FRAC >= 16) ? 16'(frac >> (FRAC - 16))
                                         : 16'(frac << (16 - FRAC));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic t_in_word ev_word(input logic cmd, input logic tmo,
                                         input logic [31:0] t_send,
                                         input logic [31:0] t_ack);
        t_in_word w;
        w.command            = cmd;
        w.sent_after_timeout = tmo;
        w.send_time_ms       = t_send;
        w.ack_time_ms        = t_ack;
        return w;
    endfunction

    function automatic t_out_word out_word(input logic [15:0] whole,
                                           input logic [15:0] frac,
                                           input logic coll);
        t_out_word r;
        r.window_whole    = whole;
        r.window_fraction = frac;
        r.collapsed       = coll;
        return r;
    endfunction

    // Mostly acks inside the delay limit, with timeouts, late acks, the
    // boundary delay and unrelated times mixed in.
    function automatic t_in_word random_event();
        int unsigned pick;
        logic [31:0] t0;
        logic [31:0] lag;
        pick = $urandom_range(0, 99);
        t0   = $urandom;
        if (pick < 12)
            return ev_word(CMD_SEND, $urandom_range(0, 3) == 0, $urandom, $urandom);
        else if (pick < 17)
            lag = $urandom;
        else if (pick < 24 && delay_limit != 32'hFFFF_FFFF) begin
            lag = $urandom;
            if (lag <= delay_limit)
                lag = delay_limit + 32'd1;
        end else if (pick < 30)
            lag = delay_limit;
        else if (delay_limit == 32'hFFFF_FFFF)
            lag = $urandom;
        else if (delay_limit > 32'd200 && $urandom_range(0, 1) == 1)
            lag = $urandom_range(0, 200);
        else
            lag = $urandom_range(0, delay_limit);
        return ev_word(CMD_ACK, 1'($urandom_range(0, 1)), t0, t0 + lag);
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    task automatic plan_event(input t_in_word w, input bit typed, input t_out_word want);
        t_plan_row row;
        row.kind    = ROW_EVENT;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.ev      = w;
        row.typed   = typed;
        row.want    = want;
        plan.push_back(row);
    endtask

    task automatic plan_write(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
        t_plan_row row;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        row.ev      = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Returns at the edge where the word is taken; the caller either sends
    // the next word or drops valid before time advances.
    task automatic push_event(input t_in_word w, input bit typed, input t_out_word want);
        int        gap;
        t_out_word predicted;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        predicted = advance_window(w);
        pending_windows.push_back(typed ? want : predicted);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_INIT_THR) begin
            thr_setting = val[15:0];
            ssthresh_q  = thr_to_fixed(thr_setting);
        end else if (idx == CFG_DELAY_LIMIT) begin
            delay_limit = val;
        end
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch on %0s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    initial begin : result_side
        int        stall;
        int        taken;
        t_out_word want;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            if (pending_windows.size() == 0) begin
                flag_mismatch("unexpected word", 32'(out_data), 32'd0);
            end else begin
                want = pending_windows.pop_front();
                if (out_data.window_whole !== want.window_whole)
                    flag_mismatch("window_whole", 32'(out_data.window_whole),
                                  32'(want.window_whole));
                if (out_data.window_fraction !== want.window_fraction)
                    flag_mismatch("window_fraction", 32'(out_data.window_fraction),
                                  32'(want.window_fraction));
                if (out_data.collapsed !== want.collapsed)
                    flag_mismatch("collapsed", 32'(out_data.collapsed),
                                  32'(want.collapsed));
            end
            taken++;
            if (taken % 50 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : event_side
        logic [15:0] thr;
        logic [31:0] lim;
        int          sent;

        thr_setting = INIT_THR_RST;
        delay_limit = DELAY_LIMIT_RST;
        cwnd_q      = ONE_Q;
        ssthresh_q  = thr_to_fixed(INIT_THR_RST);
        sent        = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: threshold 10000, limit 100, window 1.0
        plan_event(ev_word(CMD_SEND, 1'b0, '1, '1), 1'b1, out_word(16'd1, 16'd0, 1'b0));
        plan_event(ev_word(CMD_SEND, 1'b1, '1, '1), 1'b1, out_word(16'd1, 16'd0, 1'b1));
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd0, 32'd0), 1'b1,
                   out_word(16'd2, 16'd0, 1'b0));
        // delay equal to the limit holds; the timeout mark is ignored on acks
        plan_event(ev_word(CMD_ACK, 1'b1, 32'd1000, 32'd1100), 1'b1,
                   out_word(16'd2, 16'h8000, 1'b0));
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd1000, 32'd1101), 1'b1,
                   out_word(16'd2, 16'd0, 1'b1));
        // ack time wrapping past zero
        plan_event(ev_word(CMD_ACK, 1'b0, 32'hFFFF_FFFF, 32'd0), 1'b1,
                   out_word(16'd2, 16'h8000, 1'b0));
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd0, 32'hFFFF_FFFF), 1'b1,
                   out_word(16'd2, 16'd0, 1'b1));
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd1, 32'd0), 1'b1,
                   out_word(16'd2, 16'd0, 1'b1));
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd5, 32'd5), 1'b1,
                   out_word(16'd2, 16'h8000, 1'b0));
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd7, 32'd9), 1'b0, '0);
        plan_event(ev_word(CMD_ACK, 1'b0, 32'h1234_5678, 32'h1234_56AB), 1'b0, '0);
        // zero limit: any nonzero delay collapses
        plan_write(CFG_DELAY_LIMIT, 32'd0);
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd42, 32'd42), 1'b0, '0);
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd42, 32'd43), 1'b0, '0);
        // largest threshold and largest limit
        plan_write(CFG_INIT_THR, 32'h0000_FFFF);
        plan_write(CFG_DELAY_LIMIT, 32'hFFFF_FFFF);
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd0, 32'hFFFF_FFFF), 1'b0, '0);
        plan_event(ev_word(CMD_ACK, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE), 1'b0, '0);
        plan_event(ev_word(CMD_SEND, 1'b1, 32'd0, 32'd0), 1'b1,
                   out_word(16'd1, 16'd0, 1'b1));
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd100, 32'd105), 1'b0, '0);
        // zero threshold: every ack takes the reciprocal step
        plan_write(CFG_INIT_THR, 32'd0);
        plan_event(ev_word(CMD_ACK, 1'b0, 32'd3, 32'd3), 1'b0, '0);
        plan_event(ev_word(CMD_SEND, 1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A), 1'b0, '0);
        plan_event(ev_word(CMD_ACK, 1'b0, 32'hDEAD_BEEF, 32'hDEAD_BEEF), 1'b0, '0);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_event(plan[i].ev, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin thr = 16'd10000; lim = 32'd100;          end
                1: begin thr = 16'd0;     lim = 32'hFFFF_FFFF;    end
                2: begin thr = 16'hFFFF;  lim = 32'd0;            end
                3: begin thr = 16'd1;     lim = 32'd100;          end
                4: begin
                    thr = 16'($urandom_range(0, 64));
                    lim = $urandom_range(0, 5000);
                end
                5: begin thr = 16'($urandom); lim = $urandom;     end
                6: begin thr = 16'd2;     lim = 32'd1000;         end
                default: begin
                    thr = 16'($urandom_range(0, 300));
                    lim = 32'd50;
                end
            endcase
            settle();
            write_reg(CFG_INIT_THR, {16'd0, thr});
            write_reg(CFG_DELAY_LIMIT, lim);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                push_event(random_event(), 1'b0, '0);
                sent++;
                // switch between gapped and back-to-back stretches
                if (sent % 64 == 0)
                    send_burst = ($urandom_range(0, 2) == 0);
            end
        end

        settle();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
hdl/cwc_pkg.sv
hdl/congestion_window_controller.sv
bench/tb_congestion_window_controller.sv
